// ----- rtl/core/frcd_pkg.sv -----
// Package for the float recency cache decoder.
// Types, constants and helpers shared by the controller, datapath and top level.
// Depends on nothing.
package frcd_pkg;

  // field widths of the request and result
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 4;

  // ring geometry and register limits
  localparam int MAX_CACHE_BITS_DEF = 12;
  localparam int MIN_CACHE_BITS     = 2;
  localparam int CACHE_BITS_RESET   = 8;

  // one parsed float token
  typedef struct packed {
    logic [IDX_W-1:0] cache_index;
    logic [IDX_W-1:0] base_index;
    logic [VAL_W-1:0] delta_code;
    logic [VAL_W-1:0] raw_image;
  } frcd_req_t;

  // one decoded value
  typedef struct packed {
    logic [VAL_W-1:0]  value_bits;
    logic [KIND_W-1:0] case_kind;
  } frcd_res_t;

  // how a token was decoded
  typedef enum logic [KIND_W-1:0] {
    KIND_HIT   = 2'd0,
    KIND_DELTA = 2'd1,
    KIND_RAW   = 2'd2
  } frcd_kind_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWAP
  } frcd_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic exec;
    logic swap_wr;
  } frcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic swap;
  } frcd_sts_t;

  // zigzag decode with a logical shift
  function automatic logic [VAL_W-1:0] zigzag_dec(input logic [VAL_W-1:0] d);
    return (d >> 1) ^ {VAL_W{d[0]}};
  endfunction

endpackage

// ----- rtl/core/frcd_ram.sv -----
// Generic single write port, dual read port RAM with registered read data.
// No dependencies.
module frcd_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/core/frcd_ctrl.sv -----
// Controller of the float recency cache decoder: clearing pass, request
// acceptance and the execute and swap steps. Depends on frcd_pkg.
module frcd_ctrl
  import frcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  frcd_sts_t sts_i,
  output frcd_cmd_t cmd_o,
  output logic      busy_o
);

  frcd_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.swap ? ST_SWAP : ST_IDLE;
      end
      ST_SWAP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_wr = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_EXEC:  cmd_o.exec = 1'b1;
      ST_SWAP:  cmd_o.swap_wr = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

endmodule

// ----- rtl/core/frcd_dp.sv -----
// Datapath of the float recency cache decoder: ring memory, head and fill
// count, configuration register and result register. Depends on frcd_pkg, frcd_ram.
module frcd_dp
  import frcd_pkg::*;
#(
  parameter int MaxCacheBits = MAX_CACHE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  frcd_req_t        req_i,
  input  frcd_cmd_t        cmd_i,
  output frcd_sts_t        sts_o,
  output logic             done_o,
  output frcd_res_t        res_o
);

  localparam int AW  = MaxCacheBits;
  localparam int CBW = $clog2(MaxCacheBits + 1);
  localparam int CbReset = (CACHE_BITS_RESET > MaxCacheBits) ? MaxCacheBits
                                                              : CACHE_BITS_RESET;

  logic [CBW-1:0]   cb_q, cb_d;
  logic [AW-1:0]    head_q, fill_q, clr_q;
  logic [AW-1:0]    mask, fill_lim;
  logic [AW-1:0]    idx, bidx, pos, nxt, bpos;
  logic             hit;
  frcd_kind_e       kind_q;
  logic             swap_q;
  logic [AW-1:0]    pos_q, nxt_q;
  logic [VAL_W-1:0] zz_q, raw_q, hold_q;
  logic [VAL_W-1:0] rd_a, rd_b, value;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr_a;
  logic [VAL_W-1:0] ram_wdata;
  logic             done_q;
  frcd_res_t        res_q;

  // clamp the written ring size
  always_comb begin
    if (int'(cfg_wdata_i) > MaxCacheBits) begin
      cb_d = CBW'(MaxCacheBits);
    end else if (int'(cfg_wdata_i) < MIN_CACHE_BITS) begin
      cb_d = CBW'(MIN_CACHE_BITS);
    end else begin
      cb_d = CBW'(cfg_wdata_i);
    end
  end

  // ring index mask and fill limit of capacity minus 2
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (i < int'(cb_q));
    end
  end
  assign fill_lim = mask - AW'(1);

  // positions of the incoming request
  assign idx   = AW'(req_i.cache_index) & mask;
  assign bidx  = AW'(req_i.base_index) & mask;
  assign hit   = idx < fill_q;
  assign pos   = (head_q - AW'(1) - idx) & mask;
  assign nxt   = (pos + AW'(1)) & mask;
  assign bpos  = (head_q - AW'(1) - bidx) & mask;
  assign ram_raddr_a = hit ? pos : bpos;

  // configuration, head, fill count and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q   <= CBW'(CbReset);
      head_q <= '0;
      fill_q <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.clear_wr) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) begin
        cb_q   <= cb_d;
        head_q <= '0;
        fill_q <= '0;
      end else if (cmd_i.exec && kind_q != KIND_HIT) begin
        head_q <= (head_q + AW'(1)) & mask;
        if (fill_q < fill_lim) fill_q <= fill_q + AW'(1);
      end
    end
  end

  // request capture at acceptance, result capture at execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (hit) begin
        kind_q <= KIND_HIT;
      end else if (idx == fill_q) begin
        kind_q <= KIND_DELTA;
      end else begin
        kind_q <= KIND_RAW;
      end
      swap_q <= hit && (idx != '0);
      pos_q  <= hit ? pos : head_q;
      nxt_q  <= nxt;
      zz_q   <= zigzag_dec(req_i.delta_code);
      raw_q  <= req_i.raw_image;
    end
    if (cmd_i.exec) begin
      hold_q <= rd_a;
      res_q.value_bits <= value;
      res_q.case_kind  <= kind_q;
    end
  end

  // decoded value
  always_comb begin
    unique case (kind_q)
      KIND_HIT:   value = rd_a;
      KIND_DELTA: value = rd_a + zz_q;
      KIND_RAW:   value = raw_q;
      default:    value = raw_q;
    endcase
  end

  // ring write port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = value;
    priority if (cmd_i.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.exec) begin
      ram_we    = (kind_q != KIND_HIT) || swap_q;
      ram_waddr = pos_q;
      ram_wdata = (kind_q == KIND_HIT) ? rd_b : value;
    end else if (cmd_i.swap_wr) begin
      ram_we    = 1'b1;
      ram_waddr = nxt_q;
      ram_wdata = hold_q;
    end else begin
      ram_we    = 1'b0;
    end
  end

  frcd_ram #(
    .Width (VAL_W),
    .Depth (2 ** AW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (nxt),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // status and result
  assign sts_o.clear_last = (clr_q == '1);
  assign sts_o.swap       = swap_q;
  assign done_o           = done_q;
  assign res_o            = res_q;

endmodule

// ----- rtl/core/float_recency_cache_decoder_core.sv -----
// Top level of the float recency cache decoder.
// Depends on frcd_pkg, frcd_ctrl, frcd_dp and frcd_ram.
//
// Each accepted request (start_i high while busy_o is low) yields one result
// on res_o, marked by done_o for a single cycle; the receiver cannot hold it
// off and must take it in that cycle. Acceptance moves the controller to its
// execute state, and done_o is registered from that state. A request may be
// accepted again in the cycle its result shows, except after a hit that swaps
// two ring entries (any hit but on the newest entry), which passes through the
// swap state first, as the ring memory has one write port and both entries are
// written back in turn. After reset the ring is cleared to zero one entry a
// cycle, with busy_o high. Writing cache_bits (cfg_we_i) resets the head and
// fill count; a write is not held off, so write it only while idle with no request in flight.
module float_recency_cache_decoder_core
  import frcd_pkg::*;
#(
  parameter int MaxCacheBits = MAX_CACHE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             start_i,
  input  frcd_req_t        req_i,
  output logic             busy_o,
  output logic             done_o,
  output frcd_res_t        res_o
);

  frcd_cmd_t cmd;
  frcd_sts_t sts;

  // sequencing
  frcd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // ring and arithmetic
  frcd_dp #(
    .MaxCacheBits (MaxCacheBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .res_o       (res_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted request shows its result after its execute step
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("result missing two cycles after request");

  // the execute cycle is busy and carries no result
  a_exec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("execute cycle not busy or result overlaps");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without preceding work");

  // only hits can take the extra swap step
  a_swap_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.swap_wr) |-> (done_o && res_o.case_kind == KIND_HIT))
    else $error("swap step outside a hit");
`endif

endmodule
